// ----- hdl/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared sizes and types for the pairwise squared distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    // store geometry
    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 16;

    // field widths fixed by the item formats
    localparam int COORD_W = 16;
    localparam int CFG_W   = 5;
    localparam int ROW_W   = 6;
    localparam int DIST_W  = 36;

    // derived widths
    localparam int PT_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIMC_W   = $clog2(MAX_DIMS + 1);
    localparam int ST_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int ADDR_W   = $clog2(ST_DEPTH);
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [ROW_W-1:0]   t_row;
    typedef logic        [DIST_W-1:0]  t_dist;
    typedef logic        [CFG_W-1:0]   t_cfg;
    typedef logic        [ADDR_W-1:0]  t_addr;

    // store address of coordinate k of point p
    function automatic t_addr pt_addr(input logic [PT_W-1:0] p, input logic [DIM_W-1:0] k);
        t_addr base;
        base = ADDR_W'(p) * ADDR_W'(MAX_DIMS);
        return base + ADDR_W'(k);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/psd_if.sv -----
// ----------------------------------------------------------------------------
// psd channel interfaces
// Valid/ready channels for coordinates, results and the dimension register.
// ----------------------------------------------------------------------------
`default_nettype none

interface psd_in_if import psd_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord coordinate;
    logic   start_set;

    modport source (output valid, output coordinate, output start_set, input ready);
    modport sink   (input valid, input coordinate, input start_set, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_row  row_index;
    t_row  col_index;
    t_dist distance;
    logic  last_of_row;

    modport source (output valid, output row_index, output col_index,
                    output distance, output last_of_row, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input distance, input last_of_row, output ready);
endinterface

interface psd_cfg_if import psd_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg dim_count;

    modport source (output valid, output dim_count, input ready);
    modport sink   (input valid, input dim_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/psd_ram.sv -----
// ----------------------------------------------------------------------------
// psd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- hdl/pairwise_squared_distance.sv -----
// ----------------------------------------------------------------------------
// pairwise_squared_distance
// Stores points one coordinate per item and emits one lower-triangle row of
// squared distances per completed point that fits in the store, through one
// shared subtract-square-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  i_cfg   | in  | valid/ready   | dim_count
//  i_pt    | in  | valid/ready   | coordinate, start_set
//  o_res   | out | valid/ready   | row_index, col_index, distance, last_of_row
//
//  A coordinate that does not complete a point is only stored. One that
//  completes point i makes the unit walk the D coordinates of each earlier
//  point, D the effective dimension count, through the store's read port
//  pair and a three-stage pipeline.
//  i_pt.ready is low while a row is computed; a waiting result holds the unit.
//  Synchronous active-low reset clears the point count and coordinate index
//  and sets dim_count to 1; the point store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_squared_distance import psd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    psd_cfg_if.sink    i_cfg,
    psd_in_if.sink     i_pt,
    psd_out_if.source  o_res
);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_EMIT, S_DIAG} t_state;

    t_state                   r_state;
    t_cfg                     r_dim_cfg;
    logic [CNT_W-1:0]         r_count;
    logic [DIM_W-1:0]         r_coord;
    logic [DIMC_W-1:0]        r_dims;
    logic [PT_W-1:0]          r_i;
    logic [PT_W-1:0]          r_j;
    logic [DIM_W-1:0]         r_k;
    logic [2:0]               r_v;
    logic signed [DIFF_W-1:0] r_diff;
    logic [SQ_W-1:0]          r_sq;
    t_dist                    r_acc;
    logic                     r_out_valid;
    t_row                     r_out_row;
    t_row                     r_out_col;
    t_dist                    r_out_dist;
    logic                     r_out_last;

    logic [DIMC_W-1:0]        n_eff;
    logic [CNT_W-1:0]         n_cnt;
    logic [DIM_W-1:0]         n_ci;
    logic [DIMC_W-1:0]        n_ci_inc;
    logic                     w_done;
    logic                     w_store;
    logic                     w_accept;
    logic                     w_free;
    logic                     w_load;
    logic                     w_k_last;
    logic                     w_issue;
    t_coord                   w_rd_a;
    t_coord                   w_rd_b;
    logic signed [SQ_W-1:0]   w_prod;

    // clamp dimension register to 1..MAX_DIMS
    always_comb begin
        if (r_dim_cfg == '0) begin
            n_eff = DIMC_W'(1);
        end else if (int'(r_dim_cfg) > MAX_DIMS) begin
            n_eff = DIMC_W'(MAX_DIMS);
        end else begin
            n_eff = DIMC_W'(r_dim_cfg);
        end
    end

    assign n_cnt    = i_pt.start_set ? '0 : r_count;
    assign n_ci     = i_pt.start_set ? '0 : r_coord;
    assign n_ci_inc = DIMC_W'(n_ci) + DIMC_W'(1);
    assign w_done   = (n_ci_inc >= n_eff);
    assign w_store  = (n_cnt < CNT_W'(MAX_POINTS));

    assign i_pt.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_pt.valid && (r_state == S_IDLE);
    assign w_free      = !r_out_valid || o_res.ready;
    assign w_load      = w_free && (r_state inside {S_EMIT, S_DIAG});
    assign w_issue     = (r_state == S_RUN);
    assign w_k_last    = (DIMC_W'(r_k) == r_dims - DIMC_W'(1));
    assign w_prod      = r_diff * r_diff;

    psd_ram #(
        .WIDTH (COORD_W),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_store),
        .i_waddr   (pt_addr(n_cnt[PT_W-1:0], n_ci)),
        .i_wdata   (i_pt.coordinate),
        .i_raddr_a (pt_addr(r_i, r_k)),
        .i_raddr_b (pt_addr(r_j, r_k)),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim_cfg   <= CFG_W'(1);
            r_count     <= '0;
            r_coord     <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_dim_cfg <= i_cfg.dim_count;
            end

            // shared subtract-square-accumulate pipeline
            r_v <= {r_v[1:0], w_issue};
            if (r_v[0]) begin
                r_diff <= DIFF_W'(w_rd_a) - DIFF_W'(w_rd_b);
            end
            if (r_v[1]) begin
                r_sq <= unsigned'(w_prod);
            end
            if (r_v[2]) begin
                r_acc <= r_acc + DIST_W'(r_sq);
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= n_cnt;
                        if (!w_done) begin
                            r_coord <= n_ci_inc[DIM_W-1:0];
                        end else begin
                            r_coord <= '0;
                            if (w_store) begin
                                r_i    <= n_cnt[PT_W-1:0];
                                r_j    <= '0;
                                r_k    <= '0;
                                r_acc  <= '0;
                                r_dims <= n_eff;
                                r_state <= (n_cnt == '0) ? S_DIAG : S_RUN;
                            end
                        end
                    end
                end
                S_RUN: begin
                    r_k <= r_k + DIM_W'(1);
                    if (w_k_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_v == '0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_out_row   <= ROW_W'(r_i);
                        r_out_col   <= ROW_W'(r_j);
                        r_out_dist  <= r_acc;
                        r_out_last  <= 1'b0;
                        if (r_j == r_i - PT_W'(1)) begin
                            r_state <= S_DIAG;
                        end else begin
                            r_j     <= r_j + PT_W'(1);
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_DIAG: begin
                    if (w_free) begin
                        r_out_row   <= ROW_W'(r_i);
                        r_out_col   <= ROW_W'(r_i);
                        r_out_dist  <= '0;
                        r_out_last  <= 1'b1;
                        r_count     <= r_count + CNT_W'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.row_index   = r_out_row;
    assign o_res.col_index   = r_out_col;
    assign o_res.distance    = r_out_dist;
    assign o_res.last_of_row = r_out_last;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pairwise_squared_distance. It streams coordinates
// with random gaps, stalls the result side at random, mirrors the point
// store to predict every lower-triangle row and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import psd_pkg::*;

    localparam int     HALF_PERIOD  = 10;
    localparam int     RESET_CYCLES = 12;
    localparam int     DRAIN_CYCLES = 32;
    localparam int     RANDOM_ITEMS = 360;
    localparam longint RUN_LIMIT    = 100_000_000;

    localparam t_coord COORD_MIN = t_coord'(16'h8000);
    localparam t_coord COORD_MAX = t_coord'(16'h7fff);

    typedef enum int unsigned {
        PT_ALL_MIN,
        PT_ALL_MAX,
        PT_NEAR_ZERO,
        PT_EXTREME_MIX,
        PT_ANY
    } t_point_style;

    typedef struct {
        t_coord coordinate;
        logic   start_set;
    } t_coord_item;

    typedef struct {
        t_row  row_index;
        t_row  col_index;
        t_dist distance;
        logic  last_of_row;
    } t_dist_entry;

    logic clk = 1'b0;
    logic rst_n;

    psd_in_if  pt_if ();
    psd_out_if res_if ();
    psd_cfg_if cfg_if ();

    pairwise_squared_distance dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_pt    (pt_if),
        .o_res   (res_if)
    );

    always #HALF_PERIOD clk = ~clk;

    t_coord_item coord_q[$];
    t_coord_item cur_item;
    t_dist_entry row_entries[$];
    t_dist_entry head_entry;

    int unsigned in_gap_max     = 15;
    int unsigned out_stall_max  = 15;
    int unsigned in_wait        = 0;
    int unsigned out_wait       = 0;
    int unsigned queued         = 0;
    int unsigned errors         = 0;
    int unsigned checked        = 0;
    int unsigned coords_taken   = 0;
    int unsigned sets_begun     = 0;
    int unsigned points_dropped = 0;

    // mirror of the block state
    t_coord      pt_mem [MAX_POINTS][MAX_DIMS];
    int unsigned pt_cnt       = 0;
    int unsigned crd_idx      = 0;
    int unsigned set_min_dims = 1;
    t_cfg        dims_reg     = t_cfg'(1);

    function automatic int unsigned active_dims();
        if (dims_reg == 0) return 1;
        if (dims_reg > MAX_DIMS) return MAX_DIMS;
        return dims_reg;
    endfunction

    function automatic t_dist squared_distance(int unsigned a, int unsigned b,
                                               int unsigned d);
        longint acc;
        longint diff;
        acc = 0;
        for (int unsigned k = 0; k < d; k++) begin
            diff = longint'(pt_mem[a][k]) - longint'(pt_mem[b][k]);
            acc += diff * diff;
        end
        return t_dist'(acc);
    endfunction

    // store one coordinate and queue the row it completes, if any
    function automatic void take_coordinate(t_coord_item it);
        int unsigned d;
        t_dist_entry e;
        d = active_dims();
        coords_taken++;
        if (it.start_set) begin
            pt_cnt       = 0;
            crd_idx      = 0;
            set_min_dims = d;
            sets_begun++;
        end else if (d < set_min_dims) begin
            set_min_dims = d;
        end
        if (pt_cnt < MAX_POINTS && crd_idx < MAX_DIMS)
            pt_mem[pt_cnt][crd_idx] = it.coordinate;
        crd_idx++;
        if (crd_idx < d) return;
        crd_idx = 0;
        if (pt_cnt >= MAX_POINTS) begin
            points_dropped++;
            return;
        end
        for (int unsigned j = 0; j < pt_cnt; j++) begin
            e.row_index   = t_row'(pt_cnt);
            e.col_index   = t_row'(j);
            e.distance    = squared_distance(pt_cnt, j, d);
            e.last_of_row = 1'b0;
            row_entries   = {row_entries, e};
        end
        e.row_index   = t_row'(pt_cnt);
        e.col_index   = t_row'(pt_cnt);
        e.distance    = '0;
        e.last_of_row = 1'b1;
        row_entries   = {row_entries, e};
        pt_cnt++;
    endfunction

    function automatic void push_coord(t_coord c, logic s);
        t_coord_item it;
        it.coordinate = c;
        it.start_set  = s;
        coord_q = {coord_q, it};
        queued++;
    endfunction

    function automatic t_coord pick_coord(t_point_style style);
        case (style)
            PT_ALL_MIN:     return COORD_MIN;
            PT_ALL_MAX:     return COORD_MAX;
            PT_NEAR_ZERO:   return t_coord'(int'($urandom_range(0, 16)) - 8);
            PT_EXTREME_MIX: return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
            default:        return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_point_style pick_style();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 1) return PT_ALL_MIN;
        if (r < 2) return PT_ALL_MAX;
        if (r < 4) return PT_NEAR_ZERO;
        if (r < 5) return PT_EXTREME_MIX;
        return PT_ANY;
    endfunction

    // mostly small dimension counts, now and then an out-of-range one
    function automatic t_cfg pick_dims();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            case ($urandom_range(0, 4))
                0:       return t_cfg'(0);
                1:       return t_cfg'(1);
                2:       return t_cfg'(16);
                3:       return t_cfg'(17);
                default: return t_cfg'(31);
            endcase
        end
        if (r < 8) return t_cfg'($urandom_range(1, 4));
        return t_cfg'($urandom_range(5, 16));
    endfunction

    task automatic write_dims(input t_cfg value);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.dim_count <= value;
        do @(posedge clk); while (!cfg_if.ready);
        dims_reg = value;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (coord_q.size() != 0 || pt_if.valid || row_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // coordinate driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || pt_if.ready) begin
            if (pt_if.valid) begin
                take_coordinate(cur_item);
                in_wait = $urandom_range(0, in_gap_max);
            end
            if (in_wait == 0 && coord_q.size() != 0) begin
                cur_item = coord_q.pop_front();
                pt_if.valid      <= 1'b1;
                pt_if.coordinate <= cur_item.coordinate;
                pt_if.start_set  <= cur_item.start_set;
            end else begin
                pt_if.valid <= 1'b0;
                if (in_wait != 0) in_wait--;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (row_entries.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item row %0d col %0d distance %0d last %0b",
                             $time, res_if.row_index, res_if.col_index,
                             res_if.distance, res_if.last_of_row);
                end else begin
                    head_entry = row_entries.pop_front();
                    checked++;
                    if (res_if.row_index !== head_entry.row_index ||
                        res_if.col_index !== head_entry.col_index ||
                        res_if.distance !== head_entry.distance ||
                        res_if.last_of_row !== head_entry.last_of_row) begin
                        errors++;
                        $display("%0t: expected row %0d col %0d distance %0d last %0b",
                                 $time, head_entry.row_index, head_entry.col_index,
                                 head_entry.distance, head_entry.last_of_row);
                        $display("%0t:   actual row %0d col %0d distance %0d last %0b",
                                 $time, res_if.row_index, res_if.col_index,
                                 res_if.distance, res_if.last_of_row);
                    end
                end
                out_wait = $urandom_range(0, out_stall_max);
            end
            if (out_wait != 0) begin
                res_if.ready <= 1'b0;
                out_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned  d;
        int unsigned  left;
        int unsigned  npts;
        int unsigned  total;
        int unsigned  goal;
        logic         new_set;
        logic         store_filled;
        t_point_style style;

        rst_n             = 1'b0;
        pt_if.valid       = 1'b0;
        pt_if.coordinate  = '0;
        pt_if.start_set   = 1'b0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.dim_count  = '0;
        store_filled      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // zero dimension count acts as one; extreme coordinates
        write_dims(t_cfg'(0));
        push_coord(COORD_MAX, 1'b1);
        push_coord(COORD_MIN, 1'b0);
        push_coord(t_coord'(0), 1'b0);
        push_coord(t_coord'(-1), 1'b0);
        wait_idle();

        // three dimensions, then leave point 2 open after two coordinates
        write_dims(t_cfg'(3));
        push_coord(COORD_MIN, 1'b1);
        push_coord(COORD_MAX, 1'b0);
        push_coord(t_coord'(0), 1'b0);
        push_coord(COORD_MAX, 1'b0);
        push_coord(COORD_MIN, 1'b0);
        push_coord(t_coord'(-1), 1'b0);
        push_coord(t_coord'(5), 1'b0);
        push_coord(t_coord'(-5), 1'b0);
        wait_idle();

        // shrink to two mid-point: the next coordinate completes point 2
        write_dims(t_cfg'(2));
        push_coord(t_coord'(7), 1'b0);
        push_coord(COORD_MIN, 1'b0);
        push_coord(COORD_MIN, 1'b0);
        push_coord(t_coord'(1), 1'b0);
        wait_idle();

        // new set begun in the middle of a point
        push_coord(t_coord'(100), 1'b1);
        push_coord(t_coord'(200), 1'b0);
        wait_idle();

        goal = queued + RANDOM_ITEMS;
        while (queued < goal) begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 15;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            if (!store_filled && queued > 150) begin
                // overfill the store at one dimension
                store_filled = 1'b1;
                write_dims(t_cfg'(1));
                for (int i = 0; i < MAX_POINTS + 4; i++)
                    push_coord(t_coord'($urandom()), i == 0);
            end else begin
                new_set = (pt_cnt >= MAX_POINTS - 8) || ($urandom_range(0, 9) < 5);
                left    = 0;
                if (new_set) begin
                    if ($urandom_range(0, 3) != 0) write_dims(pick_dims());
                end else begin
                    // only shrink within a set so every stored coordinate read exists
                    if ($urandom_range(0, 1)) write_dims(t_cfg'($urandom_range(0, set_min_dims)));
                    d = active_dims();
                    if (crd_idx != 0) left = (crd_idx < d) ? d - crd_idx : 1;
                end
                d     = active_dims();
                npts  = (d > 8) ? $urandom_range(1, 3) : $urandom_range(1, 8);
                total = left + npts * d;
                if (d > 1 && $urandom_range(0, 4) == 0) total += $urandom_range(1, d - 1);
                style = PT_ANY;
                for (int unsigned k = 0; k < total; k++) begin
                    if (k >= left && (k - left) % d == 0) style = pick_style();
                    push_coord(pick_coord(style),
                               (new_set && k == 0) || ($urandom_range(0, 63) == 0));
                end
            end
            wait_idle();
        end

        $display("Run covered %0d coordinates in %0d sets at several dimension counts,",
                 coords_taken, sets_begun);
        $display("checked %0d distance entries, %0d points dropped on a full store.",
                 checked, points_dropped);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached, %0d results outstanding",
                 $time, row_entries.size());
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
